[rtl/core/fsb_pkg.sv]
// Shared types, command bytes and register defaults for the SPI bitstream loader.
package fsb_pkg;

  // Sequencer phases, one-hot.
  typedef enum logic [23:0] {
    PH_IDLE      = 24'h000001,
    PH_ID        = 24'h000002,
    PH_ST_INIT   = 24'h000004,
    PH_W_SETTLE  = 24'h000008,
    PH_REFRESH   = 24'h000010,
    PH_W_REFRESH = 24'h000020,
    PH_ENABLE    = 24'h000040,
    PH_W_ENABLE  = 24'h000080,
    PH_EBUSY     = 24'h000100,
    PH_W_EBUSY   = 24'h000200,
    PH_EFAIL_ST  = 24'h000400,
    PH_ERASE     = 24'h000800,
    PH_XBUSY     = 24'h001000,
    PH_W_XBUSY   = 24'h002000,
    PH_ADDR      = 24'h004000,
    PH_W_ADDR    = 24'h008000,
    PH_BCMD      = 24'h010000,
    PH_BDATA     = 24'h020000,
    PH_BREPLY    = 24'h040000,
    PH_ST_POST   = 24'h080000,
    PH_DISABLE   = 24'h100000,
    PH_NOP       = 24'h200000,
    PH_ST_FINAL  = 24'h400000,
    PH_W_RETRY   = 24'h800000
  } phase_t;

  // Input item kinds.
  localparam logic [1:0] IK_START = 2'd0;
  localparam logic [1:0] IK_REPLY = 2'd1;
  localparam logic [1:0] IK_BYTE  = 2'd2;
  localparam logic [1:0] IK_TICK  = 2'd3;

  // Result kinds.
  localparam logic [1:0] OK_SEND    = 2'd0;
  localparam logic [1:0] OK_RELEASE = 2'd1;
  localparam logic [1:0] OK_RESTART = 2'd2;
  localparam logic [1:0] OK_REPORT  = 2'd3;

  // Report codes.
  localparam logic [2:0] RC_ALREADY  = 3'd0;
  localparam logic [2:0] RC_PROGRAM  = 3'd1;
  localparam logic [2:0] RC_EN_TMO   = 3'd2;
  localparam logic [2:0] RC_ERASE_TMO = 3'd3;
  localparam logic [2:0] RC_NOT_DONE = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_EN_POLLS  = 3'd0;
  localparam logic [2:0] REG_ER_POLLS  = 3'd1;
  localparam logic [2:0] REG_ATTEMPTS  = 3'd2;
  localparam logic [2:0] REG_REFRESH   = 3'd3;
  localparam logic [2:0] REG_SETTLE    = 3'd4;
  localparam logic [2:0] REG_RETRY     = 3'd5;

  // Register reset values.
  localparam logic [15:0] RST_EN_POLLS = 16'd1000;
  localparam logic [15:0] RST_ER_POLLS = 16'd5000;
  localparam logic [2:0]  RST_ATTEMPTS = 3'd3;
  localparam logic [11:0] RST_REFRESH  = 12'd200;
  localparam logic [11:0] RST_SETTLE   = 12'd1500;
  localparam logic [11:0] RST_RETRY    = 12'd500;

  // Device command bytes and status masks.
  localparam logic [7:0]  CMD_IDCODE  = 8'hE0;
  localparam logic [7:0]  CMD_ENABLE  = 8'hC6;
  localparam logic [7:0]  CMD_ERASE   = 8'h0E;
  localparam logic [7:0]  CMD_DISABLE = 8'h26;
  localparam logic [7:0]  CMD_BUSY    = 8'hF0;
  localparam logic [7:0]  CMD_ADDR    = 8'h46;
  localparam logic [7:0]  CMD_BURST   = 8'h7A;
  localparam logic [7:0]  CMD_STATUS  = 8'h3C;
  localparam logic [7:0]  CMD_REFRESH = 8'h79;
  localparam logic [7:0]  CMD_NOP     = 8'hFF;
  localparam logic [7:0]  ERASE_ARG   = 8'h01;
  localparam logic [31:0] ST_ERR_MASK = 32'h0380_2000;
  localparam logic [31:0] ST_DONE     = 32'h0000_0100;
  localparam logic [31:0] ST_BUSY     = 32'h0000_0080;

  // Results produced by one item at most.
  localparam int MAX_RES = 2;

  typedef struct packed {
    logic [15:0] en_polls;
    logic [15:0] er_polls;
    logic [2:0]  attempts;
    logic [11:0] refresh_ms;
    logic [11:0] settle_ms;
    logic [11:0] retry_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  spi_byte;
    logic [2:0]  code;
    logic [31:0] status;
    logic [31:0] id;
    logic        err;
  } res_t;

endpackage

[rtl/core/fsb_seq.sv]
// Loader sequencer: state registers and the single-pass next-state and result logic.
module fsb_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                proc,
  input  logic [1:0]          item_kind,
  input  logic [7:0]          item_byte,
  input  logic                item_last,
  input  fsb_pkg::cfg_t       cfg,
  output logic [1:0]          wr_cnt,
  output fsb_pkg::res_t       wr_res [fsb_pkg::MAX_RES]
);

  typedef enum logic [4:0] {
    ACT_NONE   = 5'b00001,
    ACT_FRAME  = 5'b00010,
    ACT_WAIT   = 5'b00100,
    ACT_FAIL   = 5'b01000,
    ACT_REPORT = 5'b10000
  } act_t;

  fsb_pkg::phase_t ph_r, ph_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [11:0] wc_r, wc_nxt;
  logic [2:0]  ac_r, ac_nxt;
  logic [31:0] rs_r, rs_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] st_r, st_nxt;
  logic        err_r, err_nxt;

  // Byte sent at a given position of a command frame.
  function automatic logic [7:0] frame_byte(fsb_pkg::phase_t p, logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (p == fsb_pkg::PH_NOP) begin
      b = fsb_pkg::CMD_NOP;
    end else if (i == 3'd1 && p == fsb_pkg::PH_ERASE) begin
      b = fsb_pkg::ERASE_ARG;
    end else if (i == 3'd0) begin
      unique case (p) inside
        fsb_pkg::PH_ID:                    b = fsb_pkg::CMD_IDCODE;
        fsb_pkg::PH_REFRESH:               b = fsb_pkg::CMD_REFRESH;
        fsb_pkg::PH_ENABLE:                b = fsb_pkg::CMD_ENABLE;
        fsb_pkg::PH_EBUSY, fsb_pkg::PH_XBUSY: b = fsb_pkg::CMD_BUSY;
        fsb_pkg::PH_ERASE:                 b = fsb_pkg::CMD_ERASE;
        fsb_pkg::PH_ADDR:                  b = fsb_pkg::CMD_ADDR;
        fsb_pkg::PH_BCMD:                  b = fsb_pkg::CMD_BURST;
        fsb_pkg::PH_DISABLE:               b = fsb_pkg::CMD_DISABLE;
        default:                           b = fsb_pkg::CMD_STATUS;
      endcase
    end
    return b;
  endfunction

  // Number of bytes in the frame of a phase.
  function automatic logic [3:0] frame_len(fsb_pkg::phase_t p);
    logic [3:0] l;
    l = 4'd4;
    if (p == fsb_pkg::PH_ID || p == fsb_pkg::PH_ST_INIT || p == fsb_pkg::PH_EFAIL_ST ||
        p == fsb_pkg::PH_ST_POST || p == fsb_pkg::PH_ST_FINAL) begin
      l = 4'd8;
    end else if (p == fsb_pkg::PH_EBUSY || p == fsb_pkg::PH_XBUSY) begin
      l = 4'd5;
    end
    return l;
  endfunction

  function automatic logic in_frame(fsb_pkg::phase_t p);
    return p == fsb_pkg::PH_ID || p == fsb_pkg::PH_ST_INIT || p == fsb_pkg::PH_REFRESH ||
           p == fsb_pkg::PH_ENABLE || p == fsb_pkg::PH_EBUSY || p == fsb_pkg::PH_EFAIL_ST ||
           p == fsb_pkg::PH_ERASE || p == fsb_pkg::PH_XBUSY || p == fsb_pkg::PH_ADDR ||
           p == fsb_pkg::PH_BCMD || p == fsb_pkg::PH_ST_POST || p == fsb_pkg::PH_DISABLE ||
           p == fsb_pkg::PH_NOP || p == fsb_pkg::PH_ST_FINAL;
  endfunction

  function automatic logic in_wait(fsb_pkg::phase_t p);
    return p == fsb_pkg::PH_W_SETTLE || p == fsb_pkg::PH_W_REFRESH ||
           p == fsb_pkg::PH_W_ENABLE || p == fsb_pkg::PH_W_EBUSY ||
           p == fsb_pkg::PH_W_XBUSY || p == fsb_pkg::PH_W_ADDR || p == fsb_pkg::PH_W_RETRY;
  endfunction

  // One item: find the action, resolve failures and waits, then list the results.
  always_comb begin
    act_t            act;
    fsb_pkg::phase_t a_ph;
    logic [11:0]     a_t;
    logic [2:0]      a_code;
    logic            pre_v;
    logic [1:0]      pre_kind;
    logic [7:0]      pre_byte;
    logic [2:0]      lim_att;
    logic [15:0]     lim_poll;
    fsb_pkg::phase_t busy_next;
    fsb_pkg::phase_t busy_wait;
    logic [1:0]      n;

    ph_nxt  = ph_r;
    fi_nxt  = fi_r;
    pc_nxt  = pc_r;
    wc_nxt  = wc_r;
    ac_nxt  = ac_r;
    rs_nxt  = rs_r;
    id_nxt  = id_r;
    st_nxt  = st_r;
    err_nxt = err_r;
    act      = ACT_NONE;
    a_ph     = fsb_pkg::PH_IDLE;
    a_t      = 12'd0;
    a_code   = fsb_pkg::RC_ALREADY;
    pre_v    = 1'b0;
    pre_kind = fsb_pkg::OK_SEND;
    pre_byte = 8'h00;
    busy_next = fsb_pkg::PH_ERASE;
    busy_wait = fsb_pkg::PH_W_EBUSY;
    lim_poll  = cfg.en_polls;
    n = 2'd0;
    for (int k = 0; k < fsb_pkg::MAX_RES; k++) begin
      wr_res[k] = '0;
    end

    case (item_kind)
      fsb_pkg::IK_START: begin
        if (ph_r == fsb_pkg::PH_IDLE) begin
          err_nxt = 1'b0;
          ac_nxt  = 3'd0;
          act     = ACT_FRAME;
          a_ph    = fsb_pkg::PH_ID;
        end
      end
      fsb_pkg::IK_REPLY: begin
        if (ph_r == fsb_pkg::PH_BREPLY) begin
          rs_nxt = {rs_r[23:0], item_byte};
          if (fi_r != 3'd0) begin
            pre_v    = 1'b1;
            pre_kind = fsb_pkg::OK_RELEASE;
            act      = ACT_FRAME;
            a_ph     = fsb_pkg::PH_ST_POST;
          end else begin
            ph_nxt = fsb_pkg::PH_BDATA;
          end
        end else if (in_frame(ph_r)) begin
          rs_nxt = {rs_r[23:0], item_byte};
          if ({1'b0, fi_r} + 4'd1 < frame_len(ph_r)) begin
            fi_nxt   = fi_r + 3'd1;
            pre_v    = 1'b1;
            pre_kind = fsb_pkg::OK_SEND;
            pre_byte = frame_byte(ph_r, fi_r + 3'd1);
          end else if (ph_r == fsb_pkg::PH_BCMD) begin
            // Command sent: ask the host for the bitstream.
            pre_v    = 1'b1;
            pre_kind = fsb_pkg::OK_RESTART;
            ph_nxt   = fsb_pkg::PH_BDATA;
          end else begin
            pre_v    = 1'b1;
            pre_kind = fsb_pkg::OK_RELEASE;
            unique case (ph_r) inside
              fsb_pkg::PH_ID: begin
                id_nxt = rs_nxt;
                act    = ACT_FRAME;
                a_ph   = fsb_pkg::PH_ST_INIT;
              end
              fsb_pkg::PH_ST_INIT: begin
                st_nxt = rs_nxt;
                if ((rs_nxt & fsb_pkg::ST_DONE) != 32'd0) begin
                  act    = ACT_REPORT;
                  a_code = fsb_pkg::RC_ALREADY;
                end else begin
                  ac_nxt = 3'd0;
                  act    = ACT_WAIT;
                  a_ph   = fsb_pkg::PH_W_SETTLE;
                  a_t    = cfg.settle_ms;
                end
              end
              fsb_pkg::PH_REFRESH: begin
                act  = ACT_WAIT;
                a_ph = fsb_pkg::PH_W_REFRESH;
                a_t  = cfg.refresh_ms;
              end
              fsb_pkg::PH_ENABLE: begin
                pc_nxt = 16'd0;
                act    = ACT_WAIT;
                a_ph   = fsb_pkg::PH_W_ENABLE;
                a_t    = 12'd1;
              end
              fsb_pkg::PH_EBUSY, fsb_pkg::PH_XBUSY: begin
                if (ph_r == fsb_pkg::PH_XBUSY) begin
                  busy_next = fsb_pkg::PH_ADDR;
                  busy_wait = fsb_pkg::PH_W_XBUSY;
                  lim_poll  = cfg.er_polls;
                end
                if (lim_poll == 16'd0) begin
                  lim_poll = 16'd1;
                end
                if ((rs_nxt & fsb_pkg::ST_BUSY) == 32'd0) begin
                  act  = ACT_FRAME;
                  a_ph = busy_next;
                end else begin
                  pc_nxt = pc_r + 16'd1;
                  if (pc_nxt >= lim_poll) begin
                    if (ph_r == fsb_pkg::PH_EBUSY) begin
                      // Enable timeout reads status once before failing.
                      act  = ACT_FRAME;
                      a_ph = fsb_pkg::PH_EFAIL_ST;
                    end else begin
                      act    = ACT_FAIL;
                      a_code = fsb_pkg::RC_ERASE_TMO;
                    end
                  end else begin
                    act  = ACT_WAIT;
                    a_ph = busy_wait;
                    a_t  = 12'd1;
                  end
                end
              end
              fsb_pkg::PH_EFAIL_ST: begin
                st_nxt = rs_nxt;
                act    = ACT_FAIL;
                a_code = fsb_pkg::RC_EN_TMO;
              end
              fsb_pkg::PH_ERASE: begin
                pc_nxt = 16'd0;
                act    = ACT_FRAME;
                a_ph   = fsb_pkg::PH_XBUSY;
              end
              fsb_pkg::PH_ADDR: begin
                act  = ACT_WAIT;
                a_ph = fsb_pkg::PH_W_ADDR;
                a_t  = 12'd1;
              end
              fsb_pkg::PH_ST_POST: begin
                st_nxt  = rs_nxt;
                err_nxt = (rs_nxt & fsb_pkg::ST_ERR_MASK) != 32'd0;
                act     = ACT_FRAME;
                a_ph    = fsb_pkg::PH_DISABLE;
              end
              fsb_pkg::PH_DISABLE: begin
                act  = ACT_FRAME;
                a_ph = fsb_pkg::PH_NOP;
              end
              fsb_pkg::PH_NOP: begin
                act  = ACT_FRAME;
                a_ph = fsb_pkg::PH_ST_FINAL;
              end
              default: begin
                st_nxt = rs_nxt;
                if ((rs_nxt & fsb_pkg::ST_DONE) != 32'd0) begin
                  act    = ACT_REPORT;
                  a_code = fsb_pkg::RC_PROGRAM;
                end else begin
                  act    = ACT_FAIL;
                  a_code = fsb_pkg::RC_NOT_DONE;
                end
              end
            endcase
          end
        end
      end
      fsb_pkg::IK_BYTE: begin
        if (ph_r == fsb_pkg::PH_BDATA) begin
          pre_v    = 1'b1;
          pre_kind = fsb_pkg::OK_SEND;
          pre_byte = item_byte;
          fi_nxt   = {2'b00, item_last};
          ph_nxt   = fsb_pkg::PH_BREPLY;
        end
      end
      default: begin
        if (in_wait(ph_r)) begin
          wc_nxt = wc_r - 12'd1;
          if (wc_nxt == 12'd0) begin
            act  = ACT_WAIT;
            a_ph = ph_r;
            a_t  = 12'd0;
          end
        end
      end
    endcase

    // A failed attempt either reports or waits for the retry.
    lim_att = (cfg.attempts == 3'd0) ? 3'd1 : cfg.attempts;
    if (act == ACT_FAIL) begin
      ac_nxt = ac_r + 3'd1;
      if (ac_nxt >= lim_att) begin
        act = ACT_REPORT;
      end else begin
        act  = ACT_WAIT;
        a_ph = fsb_pkg::PH_W_RETRY;
        a_t  = cfg.retry_ms;
      end
    end

    // A wait that has run out starts the frame that follows it.
    if (act == ACT_WAIT) begin
      if (a_t == 12'd0) begin
        act = ACT_FRAME;
        unique case (a_ph) inside
          fsb_pkg::PH_W_SETTLE, fsb_pkg::PH_W_RETRY: begin
            err_nxt = 1'b0;
            a_ph    = fsb_pkg::PH_REFRESH;
          end
          fsb_pkg::PH_W_REFRESH:                   a_ph = fsb_pkg::PH_ENABLE;
          fsb_pkg::PH_W_ENABLE, fsb_pkg::PH_W_EBUSY: a_ph = fsb_pkg::PH_EBUSY;
          fsb_pkg::PH_W_XBUSY:                     a_ph = fsb_pkg::PH_XBUSY;
          default:                                 a_ph = fsb_pkg::PH_BCMD;
        endcase
      end else begin
        act    = ACT_NONE;
        ph_nxt = a_ph;
        wc_nxt = a_t;
      end
    end

    // Result list.
    if (pre_v) begin
      wr_res[0].kind     = pre_kind;
      wr_res[0].spi_byte = pre_byte;
      n = 2'd1;
    end
    if (act == ACT_FRAME) begin
      ph_nxt = a_ph;
      fi_nxt = 3'd0;
      wr_res[n[0]].kind     = fsb_pkg::OK_SEND;
      wr_res[n[0]].spi_byte = frame_byte(a_ph, 3'd0);
      n = n + 2'd1;
    end else if (act == ACT_REPORT) begin
      ph_nxt = fsb_pkg::PH_IDLE;
      wr_res[n[0]].kind   = fsb_pkg::OK_REPORT;
      wr_res[n[0]].code   = a_code;
      wr_res[n[0]].status = st_nxt;
      wr_res[n[0]].id     = id_nxt;
      wr_res[n[0]].err    = err_nxt;
      n = n + 2'd1;
    end
    wr_cnt = proc ? n : 2'd0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= fsb_pkg::PH_IDLE;
      fi_r  <= '0;
      pc_r  <= '0;
      wc_r  <= '0;
      ac_r  <= '0;
      rs_r  <= '0;
      id_r  <= '0;
      st_r  <= '0;
      err_r <= 1'b0;
    end else if (proc) begin
      ph_r  <= ph_nxt;
      fi_r  <= fi_nxt;
      pc_r  <= pc_nxt;
      wc_r  <= wc_nxt;
      ac_r  <= ac_nxt;
      rs_r  <= rs_nxt;
      id_r  <= id_nxt;
      st_r  <= st_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

[rtl/core/fsb_outq.sv]
// Four-entry result queue taking up to two results a cycle and giving one.
module fsb_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    wr_cnt,
  input  fsb_pkg::res_t wr_res [fsb_pkg::MAX_RES],
  input  logic          pop,
  output fsb_pkg::res_t rd_res,
  output logic [2:0]    count
);

  fsb_pkg::res_t mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign wp_nxt  = wp_r + wr_cnt;
  assign rp_nxt  = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, wr_cnt} - {2'b00, pop};
  assign rd_res  = mem_r[rp_r];
  assign count   = cnt_r;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wp_r] <= wr_res[0];
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wp_r + 2'd1] <= wr_res[1];
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/fpga_spi_bitstream_loader_core.sv]
// Top level of the slave-SPI bitstream loader: input register, config registers, queue.
// out_tvalid for a result rises once its item has left the input register and is queued.
// Throughput: one input transaction per cycle while each gives at most one result and
// the output drains; the queue is read one result wide, so a second result waits behind.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears the queue
// and loads the register defaults.
module fpga_spi_bitstream_loader_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] spi_byte, [10:8] result_code,
                                  // [42:11] status_word, [74:43] id_word,
                                  // [75] bitstream_error, [79:76] zero
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  fsb_pkg::cfg_t cfg_r;
  logic          vld_r;
  logic [1:0]    kind_r;
  logic [7:0]    byte_r;
  logic          last_r;
  logic          proc;
  logic          pop;
  logic [2:0]    qcount;
  logic [2:0]    qafter;
  logic [1:0]    wr_cnt;
  fsb_pkg::res_t wr_res [fsb_pkg::MAX_RES];
  fsb_pkg::res_t rd_res;

  // Work on the held item once the queue has room for its results.
  assign pop       = out_tvalid & out_tready;
  assign qafter    = qcount - {2'b00, pop};
  assign proc      = vld_r & (qafter <= 3'd2);
  assign in_tready = ~vld_r | proc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en_polls   <= fsb_pkg::RST_EN_POLLS;
      cfg_r.er_polls   <= fsb_pkg::RST_ER_POLLS;
      cfg_r.attempts   <= fsb_pkg::RST_ATTEMPTS;
      cfg_r.refresh_ms <= fsb_pkg::RST_REFRESH;
      cfg_r.settle_ms  <= fsb_pkg::RST_SETTLE;
      cfg_r.retry_ms   <= fsb_pkg::RST_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsb_pkg::REG_EN_POLLS: cfg_r.en_polls   <= cfg_wdata;
        fsb_pkg::REG_ER_POLLS: cfg_r.er_polls   <= cfg_wdata;
        fsb_pkg::REG_ATTEMPTS: cfg_r.attempts   <= cfg_wdata[2:0];
        fsb_pkg::REG_REFRESH:  cfg_r.refresh_ms <= cfg_wdata[11:0];
        fsb_pkg::REG_SETTLE:   cfg_r.settle_ms  <= cfg_wdata[11:0];
        fsb_pkg::REG_RETRY:    cfg_r.retry_ms   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  fsb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .item_kind (kind_r),
    .item_byte (byte_r),
    .item_last (last_r),
    .cfg       (cfg_r),
    .wr_cnt    (wr_cnt),
    .wr_res    (wr_res)
  );

  fsb_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cnt (wr_cnt),
    .wr_res (wr_res),
    .pop    (pop),
    .rd_res (rd_res),
    .count  (qcount)
  );

  // Result channel.
  assign out_tvalid = qcount != 3'd0;
  assign out_tuser  = rd_res.kind;
  assign out_tdata  = {4'b0000, rd_res.err, rd_res.id, rd_res.status, rd_res.code,
                       rd_res.spi_byte};

endmodule
